[rtl/core/cspf_pkg.sv]
// cspf_pkg: types, codes, constants and helper functions of the command stream packet framer
// depends on nothing; imported by command_stream_packet_framer_unit
`timescale 1ns / 1ps

package cspf_pkg;

    localparam int unsigned MAX_RESULTS = 7;
    localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] START_BYTE     = 8'hD5;
    localparam logic [7:0] CRC_POLY       = 8'h8C;
    localparam logic [7:0] TOOL_CMD       = 8'd136;
    localparam logic [7:0] FIRST_CMD      = 8'd129;
    localparam logic [7:0] LAST_CMD       = 8'd144;
    localparam logic [7:0] MAX_TOOL_COUNT = 8'd251;
    localparam logic [7:0] TOOL_HDR_BYTES = 8'd3;

    // body lengths of commands 129..144, tool-action entry unused
    localparam logic [7:0] BODY_LEN [16] = '{
        8'd16, 8'd12, 8'd7, 8'd7, 8'd4, 8'd1, 8'd5, 8'd0,
        8'd1,  8'd2,  8'd24, 8'd20, 8'd5, 8'd25, 8'd1, 8'd1
    };

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNKNOWN   = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_TOO_LONG  = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        err_t       error_code;
    } out_item_t;

    // one byte through the reflected crc-8, lsb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] body_len(input logic [7:0] cmd);
        logic [7:0] off;
        off = cmd - FIRST_CMD;
        return BODY_LEN[off[3:0]];
    endfunction

endpackage

[rtl/core/command_stream_packet_framer_unit.sv]
// command_stream_packet_framer_unit: top level, rebuilds framed packets from a command byte stream
// depends on cspf_pkg (types, codes, crc and length helpers)
`timescale 1ns / 1ps

// Takes the command stream one byte per item on the cmd channel and sends the framed
// packet one byte per item on the pkt channel: start byte 0xd5, length byte (command plus
// body), the command byte, the body, then a crc-8 (reflected poly 0x8c, initial value 0)
// over the command byte and body. Body lengths of commands 129..144 come from a fixed
// table; command 136 (tool action) first takes three header bytes, and its body is the
// third header byte plus three. An unknown command, end of file inside a packet, or a
// tool-action count above 251 gives one error item (byte 0, end_of_packet set, error
// code) and the block then ignores every input until reset. Each accepted item is
// decoded in the cycle it is taken and its results (none up to seven) are loaded into
// a seven-entry output shift buffer; they appear from the next cycle on. The buffer
// drains one item per cycle while pkt_ready is high, and under that condition body bytes
// pass at one per cycle; a fixed command yields three results, a full tool-action
// header burst six or seven. The next input item is taken in the same cycle the last
// buffered result leaves, or at once when the buffer is empty.
// There is no configuration and no clearing pass after reset.
module command_stream_packet_framer_unit
    import cspf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  in_item_t  cmd,
    output logic      pkt_valid,
    input  logic      pkt_ready,
    output out_item_t pkt
);

    // framing state
    phase_t       phase_reg, phase_next;
    logic [7:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]   crc_reg, crc_next;
    logic [7:0]   held_cmd_reg, held_cmd_next;
    logic [1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]   held_hdr_reg [2];
    logic         hdr_wr;

    // output shift buffer, head item at entry 0
    out_item_t        buf_reg [MAX_RESULTS];
    out_item_t        buf_next [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // results of the item being accepted
    out_item_t        ld [MAX_RESULTS];
    logic [CNT_W-1:0] ld_cnt;

    logic       cmd_fire;
    logic       pkt_fire;
    logic [7:0] b;
    logic       eof;
    logic [7:0] crc_first;
    logic [7:0] crc_upd;
    logic [7:0] left_dec;

    assign b         = cmd.in_byte;
    assign eof       = cmd.end_of_file;
    assign pkt_valid = (cnt_reg != '0);
    assign pkt       = buf_reg[0];
    assign pkt_fire  = pkt_valid && pkt_ready;
    // take a new item once the buffer is empty or its last item leaves now
    assign cmd_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pkt_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign crc_first = crc8_step(8'd0, b);
    assign crc_upd   = crc8_step(crc_reg, b);
    assign left_dec  = (bytes_left_reg != 8'd0) ? (bytes_left_reg - 8'd1) : 8'd0;

    // decode of one accepted item: next state and its result items
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        held_cmd_next   = held_cmd_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_wr          = 1'b0;
        ld_cnt          = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            ld[i] = '{out_byte: 8'd0, end_of_packet: 1'b0, error_code: ERR_NONE};
        end

        if (cmd_fire)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (eof)
                    begin
                        // end of file between packets: nothing to do
                        phase_next = PH_IDLE;
                    end
                    else if ((b < FIRST_CMD) || (b > LAST_CMD))
                    begin
                        ld[0]      = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                       error_code: ERR_UNKNOWN};
                        ld_cnt     = CNT_W'(1);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        held_cmd_next = b;
                        crc_next      = crc_first;
                        if (b == TOOL_CMD)
                        begin
                            hdr_cnt_next = 2'd0;
                            phase_next   = PH_HEADER;
                        end
                        else
                        begin
                            bytes_left_next = body_len(b);
                            ld[0].out_byte  = START_BYTE;
                            ld[1].out_byte  = body_len(b) + 8'd1;
                            ld[2].out_byte  = b;
                            ld_cnt          = CNT_W'(3);
                            phase_next      = PH_BODY;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (eof)
                    begin
                        ld[0]      = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                       error_code: ERR_TRUNCATED};
                        ld_cnt     = CNT_W'(1);
                        phase_next = PH_HALT;
                    end
                    else if (hdr_cnt_reg < 2'd2)
                    begin
                        hdr_wr       = 1'b1;
                        crc_next     = crc_upd;
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                    else if (b > MAX_TOOL_COUNT)
                    begin
                        ld[0]      = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                       error_code: ERR_TOO_LONG};
                        ld_cnt     = CNT_W'(1);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        // third header byte: whole header burst goes out at once
                        crc_next        = crc_upd;
                        hdr_cnt_next    = 2'd0;
                        bytes_left_next = b;
                        ld[0].out_byte  = START_BYTE;
                        ld[1].out_byte  = b + TOOL_HDR_BYTES + 8'd1;
                        ld[2].out_byte  = held_cmd_reg;
                        ld[3].out_byte  = held_hdr_reg[0];
                        ld[4].out_byte  = held_hdr_reg[1];
                        ld[5].out_byte  = b;
                        if (b == 8'd0)
                        begin
                            ld[6].out_byte      = crc_upd;
                            ld[6].end_of_packet = 1'b1;
                            ld_cnt              = CNT_W'(7);
                            phase_next          = PH_IDLE;
                        end
                        else
                        begin
                            ld_cnt     = CNT_W'(6);
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (eof)
                    begin
                        ld[0]      = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                       error_code: ERR_TRUNCATED};
                        ld_cnt     = CNT_W'(1);
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        crc_next        = crc_upd;
                        bytes_left_next = left_dec;
                        ld[0].out_byte  = b;
                        if (left_dec == 8'd0)
                        begin
                            ld[1].out_byte      = crc_upd;
                            ld[1].end_of_packet = 1'b1;
                            ld_cnt              = CNT_W'(2);
                            phase_next          = PH_IDLE;
                        end
                        else
                        begin
                            ld_cnt = CNT_W'(1);
                        end
                    end
                end
                PH_HALT:
                begin
                    // halted until reset, input items are dropped
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // buffer shift on a pop, reload on an accept (buffer is then empty or emptying)
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next = cnt_reg;
        if (pkt_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd_fire)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_next[i] = ld[i];
            end
            cnt_next = ld_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= 8'd0;
            crc_reg        <= 8'd0;
            held_cmd_reg   <= 8'd0;
            hdr_cnt_reg    <= 2'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            held_cmd_reg   <= held_cmd_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            held_hdr_reg[hdr_cnt_reg[0]] <= b;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    // halted stays halted until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("framer left the halted state without reset");

    // an error item carries a zero byte and closes the packet
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && (pkt.error_code != ERR_NONE))
            |-> (pkt.end_of_packet && (pkt.out_byte == 8'd0)))
        else $error("malformed error item");

    // an error item only waits while the framer is halted
    a_err_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && (pkt.error_code != ERR_NONE)) |-> (phase_reg == PH_HALT))
        else $error("error item pending outside the halted state");

    // header count is cleared in the idle and body phases
    a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_IDLE) || (phase_reg == PH_BODY)) |-> (hdr_cnt_reg == 2'd0))
        else $error("stale header count");

endmodule
